### design/sisf_pkg.sv
// Shared types and constants of the satellite image sample fetch block.
// No dependencies; every other file but sisf_ram imports this package.
package sisf_pkg;

  localparam int IMAGE_BYTES    = 262144;
  localparam int TWO_BYTE_SCALE = 80;

  localparam int ADDR_W  = $clog2(IMAGE_BYTES);
  localparam int BANK_W  = ADDR_W - 1;
  localparam int BANK_D  = IMAGE_BYTES / 2;

  localparam int LOAD_ADDR_W = 18;
  localparam int COORD_W     = 16;
  localparam int RES_W       = 10;
  localparam int CNT_W       = 13;
  localparam int BPE_W       = 2;
  localparam int PREFIX_W    = 10;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_DATA_W   = 64;
  localparam int OUT_DATA_W  = 8;

  // axis limits and rounding divider
  localparam int LIM_W      = 25;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int DIVIDEND_W = DIFF_W + 1;
  localparam int DIVISOR_W  = RES_W + 1;
  localparam int QUOT_W     = CNT_W;
  localparam int DIVL_W     = DIVISOR_W + QUOT_W - 1;
  localparam int SPAN_W     = CNT_W + RES_W;

  // byte position
  localparam int LINELEN_W = CNT_W + 2;
  localparam int PROD_W    = QUOT_W + LINELEN_W;
  localparam int XB_W      = QUOT_W + 1;
  localparam int POS_W     = PROD_W + 2;

  // queues
  localparam int QUEUE_DEPTH = 32;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int OQ_DEPTH    = 4;
  localparam int OQ_AW       = $clog2(OQ_DEPTH);

  // two-byte scaling by reciprocal multiply
  localparam int SCALE_SH = 32;
  localparam int RECIP_W  = SCALE_SH + 1;
  localparam logic [RECIP_W-1:0] SCALE_RECIP =
    RECIP_W'(((64'd1 << SCALE_SH) + 64'(TWO_BYTE_SCALE) - 64'd1) / 64'(TWO_BYTE_SCALE));
  localparam int TOO_BIG_LIMIT = 256 * TWO_BYTE_SCALE;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [BPE_W-1:0] BPE_ONE = 2'd1;
  localparam logic [BPE_W-1:0] BPE_TWO = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_LINE  = 3'd0,
    CFG_FIRST_ELEM  = 3'd1,
    CFG_LINE_RES    = 3'd2,
    CFG_ELEM_RES    = 3'd3,
    CFG_IMAGE_LINES = 3'd4,
    CFG_IMAGE_ELEMS = 3'd5,
    CFG_BYTES_PER   = 3'd6,
    CFG_PREFIX_LEN  = 3'd7
  } cfg_idx_t;

  // one command from front to back
  typedef struct packed {
    logic              is_query;
    logic              outside;
    logic              two_byte;
    logic              wr_en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } cmd_t;

  typedef struct packed {
    logic [7:0] sample;
    logic       outside;
    logic       too_big;
  } res_t;

endpackage

### design/sisf_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
module sisf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/sisf_front.sv
// Front part: configuration registers, limit checks, rounding division and
// byte position. Depends on sisf_pkg.
module sisf_front import sisf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   accept,
  input  logic                   op,
  input  logic [LOAD_ADDR_W-1:0] load_addr,
  input  logic [7:0]             load_byte,
  input  logic [COORD_W-1:0]     sat_line,
  input  logic [COORD_W-1:0]     sat_elem,
  output logic                   cmd_valid,
  output cmd_t                   cmd
);

  typedef struct packed {
    logic                   op;
    logic                   outside;
    logic [LOAD_ADDR_W-1:0] load_addr;
    logic [7:0]             load_byte;
    logic [DIVIDEND_W-1:0]  rem_l;
    logic [DIVIDEND_W-1:0]  rem_e;
    logic [QUOT_W-1:0]      q_l;
    logic [QUOT_W-1:0]      q_e;
  } div_t;

  typedef struct packed {
    logic                   op;
    logic                   outside;
    logic [LOAD_ADDR_W-1:0] load_addr;
    logic [7:0]             load_byte;
    logic [PROD_W-1:0]      prod;
    logic [XB_W-1:0]        xb;
  } mul_t;

  // configuration
  logic signed [COORD_W-1:0] first_line_r, first_elem_r;
  logic [RES_W-1:0]          line_res_r, elem_res_r;
  logic [CNT_W-1:0]          image_lines_r, image_elems_r;
  logic [BPE_W-1:0]          bpe_r;
  logic [PREFIX_W-1:0]       prefix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_line_r  <= '0;
      first_elem_r  <= '0;
      line_res_r    <= RES_W'(1);
      elem_res_r    <= RES_W'(1);
      image_lines_r <= CNT_W'(1);
      image_elems_r <= CNT_W'(1);
      bpe_r         <= BPE_ONE;
      prefix_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_FIRST_LINE:  first_line_r  <= cfg_wdata;
        CFG_FIRST_ELEM:  first_elem_r  <= cfg_wdata;
        CFG_LINE_RES:    line_res_r    <= cfg_wdata[RES_W-1:0];
        CFG_ELEM_RES:    elem_res_r    <= cfg_wdata[RES_W-1:0];
        CFG_IMAGE_LINES: image_lines_r <= cfg_wdata[CNT_W-1:0];
        CFG_IMAGE_ELEMS: image_elems_r <= cfg_wdata[CNT_W-1:0];
        CFG_BYTES_PER:   bpe_r         <= cfg_wdata[BPE_W-1:0];
        CFG_PREFIX_LEN:  prefix_r      <= cfg_wdata[PREFIX_W-1:0];
        default: ;
      endcase
    end
  end

  // settings derived from configuration, refreshed every cycle
  logic [RES_W-1:0]         rl_nxt, re_nxt, rl_r, re_r;
  logic signed [LIM_W-1:0]  last_l_nxt, last_e_nxt, last_l_r, last_e_r;
  logic [LINELEN_W-1:0]     linelen_nxt, linelen_r;
  logic                     two_r, bpe_ok_r, lines_ok_r, elems_ok_r;
  logic [SPAN_W-1:0]        span_l, span_e;

  always_comb begin
    rl_nxt      = (line_res_r == '0) ? RES_W'(1) : line_res_r;
    re_nxt      = (elem_res_r == '0) ? RES_W'(1) : elem_res_r;
    span_l      = SPAN_W'(image_lines_r - CNT_W'(1)) * SPAN_W'(rl_nxt);
    span_e      = SPAN_W'(image_elems_r - CNT_W'(1)) * SPAN_W'(re_nxt);
    last_l_nxt  = LIM_W'(first_line_r) + signed'(LIM_W'(span_l));
    last_e_nxt  = LIM_W'(first_elem_r) + signed'(LIM_W'(span_e));
    linelen_nxt = ((bpe_r == BPE_TWO) ? {1'b0, image_elems_r, 1'b0}
                                      : LINELEN_W'(image_elems_r))
                  + LINELEN_W'(prefix_r);
  end

  always_ff @(posedge clk) begin
    rl_r       <= rl_nxt;
    re_r       <= re_nxt;
    last_l_r   <= last_l_nxt;
    last_e_r   <= last_e_nxt;
    linelen_r  <= linelen_nxt;
    two_r      <= (bpe_r == BPE_TWO);
    bpe_ok_r   <= (bpe_r == BPE_ONE) || (bpe_r == BPE_TWO);
    lines_ok_r <= (image_lines_r != '0);
    elems_ok_r <= (image_elems_r != '0);
  end

  // input stage
  logic                   v0_r;
  logic                   op_r;
  logic [LOAD_ADDR_W-1:0] la_r;
  logic [7:0]             lb_r;
  logic signed [COORD_W-1:0] sl_r, se_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= op;
      la_r <= load_addr;
      lb_r <= load_byte;
      sl_r <= sat_line;
      se_r <= sat_elem;
    end
  end

  // limit check and dividend setup
  logic signed [LIM_W-1:0] cl, ce, fl, fe, dl, de;
  logic                    in_l, in_e;
  div_t                    a_nxt;

  always_comb begin
    cl   = LIM_W'(sl_r);
    ce   = LIM_W'(se_r);
    fl   = LIM_W'(first_line_r);
    fe   = LIM_W'(first_elem_r);
    dl   = cl - fl;
    de   = ce - fe;
    in_l = lines_ok_r && (cl >= fl) && (cl <= last_l_r);
    in_e = elems_ok_r && (ce >= fe) && (ce <= last_e_r);
    a_nxt.op        = op_r;
    a_nxt.outside   = !(in_l && in_e && bpe_ok_r);
    a_nxt.load_addr = la_r;
    a_nxt.load_byte = lb_r;
    a_nxt.rem_l     = {dl[DIFF_W-1:0], 1'b0} + DIVIDEND_W'(rl_r);
    a_nxt.rem_e     = {de[DIFF_W-1:0], 1'b0} + DIVIDEND_W'(re_r);
    a_nxt.q_l       = '0;
    a_nxt.q_e       = '0;
  end

  // restoring division, one quotient bit per stage
  logic va_r;
  div_t a_r;
  logic dv_r [QUOT_W];
  div_t dp_r [QUOT_W];
  div_t dp_nxt [QUOT_W];
  logic [DIVL_W-1:0] dsh_l [QUOT_W];
  logic [DIVL_W-1:0] dsh_e [QUOT_W];

  always_comb begin
    for (int k = 0; k < QUOT_W; k++) begin
      dp_nxt[k] = (k == 0) ? a_r : dp_r[(k == 0) ? 0 : k - 1];
      dsh_l[k]  = DIVL_W'({rl_r, 1'b0}) << (QUOT_W - 1 - k);
      dsh_e[k]  = DIVL_W'({re_r, 1'b0}) << (QUOT_W - 1 - k);
      if (DIVL_W'(dp_nxt[k].rem_l) >= dsh_l[k]) begin
        dp_nxt[k].rem_l = dp_nxt[k].rem_l - DIVIDEND_W'(dsh_l[k]);
        dp_nxt[k].q_l[QUOT_W-1-k] = 1'b1;
      end
      if (DIVL_W'(dp_nxt[k].rem_e) >= dsh_e[k]) begin
        dp_nxt[k].rem_e = dp_nxt[k].rem_e - DIVIDEND_W'(dsh_e[k]);
        dp_nxt[k].q_e[QUOT_W-1-k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      for (int k = 0; k < QUOT_W; k++) begin
        dv_r[k] <= 1'b0;
      end
    end else begin
      va_r <= v0_r;
      for (int k = 0; k < QUOT_W; k++) begin
        dv_r[k] <= (k == 0) ? va_r : dv_r[(k == 0) ? 0 : k - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    for (int k = 0; k < QUOT_W; k++) begin
      dp_r[k] <= dp_nxt[k];
    end
  end

  // line offset multiply
  logic vm_r;
  mul_t m_r, m_nxt;
  div_t dl_last;

  always_comb begin
    dl_last         = dp_r[QUOT_W-1];
    m_nxt.op        = dl_last.op;
    m_nxt.outside   = dl_last.outside;
    m_nxt.load_addr = dl_last.load_addr;
    m_nxt.load_byte = dl_last.load_byte;
    m_nxt.prod      = PROD_W'(dl_last.q_l) * PROD_W'(linelen_r);
    m_nxt.xb        = two_r ? {dl_last.q_e, 1'b0} : XB_W'(dl_last.q_e);
  end

  // final byte position and command
  logic [POS_W-1:0] pos, pos_end;
  cmd_t             cmd_nxt, cmd_r;
  logic             vp_r;

  always_comb begin
    pos     = POS_W'(m_r.prod) + POS_W'(prefix_r) + POS_W'(m_r.xb);
    pos_end = pos + (two_r ? POS_W'(2) : POS_W'(1));
    cmd_nxt.is_query = (m_r.op == OP_QUERY);
    cmd_nxt.two_byte = two_r;
    cmd_nxt.wdata    = m_r.load_byte;
    if (m_r.op == OP_QUERY) begin
      cmd_nxt.outside = m_r.outside || (32'(pos_end) > IMAGE_BYTES);
      cmd_nxt.wr_en   = 1'b0;
      cmd_nxt.addr    = pos[ADDR_W-1:0];
    end else begin
      cmd_nxt.outside = 1'b0;
      cmd_nxt.wr_en   = (32'(m_r.load_addr) < IMAGE_BYTES);
      cmd_nxt.addr    = ADDR_W'(m_r.load_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
      vp_r <= 1'b0;
    end else begin
      vm_r <= dv_r[QUOT_W-1];
      vp_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    m_r   <= m_nxt;
    cmd_r <= cmd_nxt;
  end

  assign cmd_valid = vp_r;
  assign cmd       = cmd_r;

endmodule

### design/sisf_queue.sv
// Command queue between front and back parts.
// Depends on sisf_pkg.
module sisf_queue import sisf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic head_valid,
  output cmd_t head
);

  cmd_t                mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_r, rd_r;
  logic [QUEUE_AW:0]   count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_r <= rd_r + QUEUE_AW'(1);
      end
      count_r <= count_r + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_r];

endmodule

### design/sisf_back.sv
// Back part: image store in two byte banks, sample assembly, scaling and
// result queue. Depends on sisf_pkg and sisf_ram.
module sisf_back import sisf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  cmd_t       head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output res_t       out_res
);

  logic [OQ_AW:0] oocc_r;
  logic           deliver;

  // hold queries until the result queue is sure to have room
  assign pop     = head_valid && (!head.is_query || (oocc_r < (OQ_AW+1)'(OQ_DEPTH)));
  assign deliver = out_valid && out_ready;

  logic             we_even, we_odd;
  logic [BANK_W-1:0] waddr, ra_even, ra_odd;
  logic [ADDR_W-1:0] addr_inc;
  logic [7:0]        q_even, q_odd;

  always_comb begin
    addr_inc = head.addr + ADDR_W'(1);
    waddr    = head.addr[ADDR_W-1:1];
    ra_even  = addr_inc[ADDR_W-1:1];
    ra_odd   = head.addr[ADDR_W-1:1];
    we_even  = pop && !head.is_query && head.wr_en && !head.addr[0];
    we_odd   = pop && !head.is_query && head.wr_en && head.addr[0];
  end

  sisf_ram #(.WIDTH(8), .DEPTH(BANK_D)) u_even (
    .clk   (clk),
    .we    (we_even),
    .waddr (waddr),
    .wdata (head.wdata),
    .raddr (ra_even),
    .rdata (q_even)
  );

  sisf_ram #(.WIDTH(8), .DEPTH(BANK_D)) u_odd (
    .clk   (clk),
    .we    (we_odd),
    .waddr (waddr),
    .wdata (head.wdata),
    .raddr (ra_odd),
    .rdata (q_odd)
  );

  logic rv_r, r_outside_r, r_two_r, r_pos0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= 1'b0;
    end else begin
      rv_r <= pop && head.is_query;
    end
  end

  always_ff @(posedge clk) begin
    r_outside_r <= head.outside;
    r_two_r     <= head.two_byte;
    r_pos0_r    <= head.addr[0];
  end

  logic [7:0]                lo, hi;
  logic [15:0]               val;
  logic [16+RECIP_W-1:0]     scaled;
  logic                      too;
  res_t                      res;

  always_comb begin
    lo     = r_pos0_r ? q_odd : q_even;
    hi     = r_pos0_r ? q_even : q_odd;
    val    = {hi, lo};
    scaled = (16+RECIP_W)'(val) * (16+RECIP_W)'(SCALE_RECIP);
    too    = (32'(val) >= TOO_BIG_LIMIT);
    res    = '0;
    if (r_outside_r) begin
      res.outside = 1'b1;
    end else if (!r_two_r) begin
      res.sample = lo;
    end else if (too) begin
      res.too_big = 1'b1;
    end else begin
      res.sample = scaled[SCALE_SH+7:SCALE_SH];
    end
  end

  // result queue
  res_t           oq_r [OQ_DEPTH];
  logic [OQ_AW-1:0] owr_r, ord_r;
  logic [OQ_AW:0]   ocnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r  <= '0;
      ord_r  <= '0;
      ocnt_r <= '0;
      oocc_r <= '0;
    end else begin
      if (rv_r) begin
        owr_r <= owr_r + OQ_AW'(1);
      end
      if (deliver) begin
        ord_r <= ord_r + OQ_AW'(1);
      end
      ocnt_r <= ocnt_r + (OQ_AW+1)'(rv_r) - (OQ_AW+1)'(deliver);
      oocc_r <= oocc_r + (OQ_AW+1)'(pop && head.is_query) - (OQ_AW+1)'(deliver);
    end
  end

  always_ff @(posedge clk) begin
    if (rv_r) begin
      oq_r[owr_r] <= res;
    end
  end

  assign out_valid = (ocnt_r != '0);
  assign out_res   = oq_r[ord_r];

endmodule

### design/satellite_image_sample_fetch.sv
// Top level of the satellite image sample fetch block.
// Depends on sisf_pkg, sisf_front, sisf_queue, sisf_back.
//
// Input items arrive on the in_ stream. in_tuser = 0 is a load: one byte
// is written to the image store at load_addr, and no result follows.
// in_tuser = 1 is a query: one result item leaves on the out_ stream with
// the sample and the outside / too_big flags, in the order of the queries.
// Settings must be written on the cfg_ port while the block is idle;
// the user must keep to this, as the block itself does not enforce it.
// Throughput is one item per cycle while in_tready is high. The depth of
// the query path is set by the 13-stage rounding divider, the line
// multiply, the command queue and the registered read of the store banks.
// Up to 32 items may be in the front pipeline and command queue; when the
// receiver stalls, results collect in a 4-entry result queue, the command
// queue fills behind it and in_tready drops. Loads keep draining meanwhile
// until a query reaches the head.
// Reset clears settings to their defaults and empties all queues; the
// image store is not cleared and must be loaded before it is read.
module satellite_image_sample_fetch import sisf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // load_addr[17:0], load_byte[25:18], sat_line[41:26], sat_elem[57:42]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // op[0]
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // sample[7:0]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // outside[0], too_big[1]
  output logic [1:0]            out_tuser
);

  logic              accept;
  logic              cmd_valid, head_valid, pop;
  cmd_t              cmd, head;
  res_t              res;
  logic [QUEUE_AW:0] occ_r;

  // items between acceptance and leaving the command queue
  assign in_tready = (occ_r < (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_r + (QUEUE_AW+1)'(accept) - (QUEUE_AW+1)'(pop);
    end
  end

  sisf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .op        (in_tuser),
    .load_addr (in_tdata[17:0]),
    .load_byte (in_tdata[25:18]),
    .sat_line  (in_tdata[41:26]),
    .sat_elem  (in_tdata[57:42]),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  sisf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (cmd_valid),
    .push_cmd   (cmd),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  sisf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (res)
  );

  assign out_tdata = res.sample;
  assign out_tuser = {res.too_big, res.outside};

endmodule
